>>> rtl/hims_pkg.sv
// Shared constants, types and the bucket hash for the hashed ID membership set.
`default_nettype none

package hims_pkg;

  localparam int unsigned IdW     = 32;
  localparam int unsigned Buckets = 64;
  localparam int unsigned Ways    = 4;
  localparam int unsigned BucketW = $clog2(Buckets);
  localparam int unsigned WayW    = $clog2(Ways);

  localparam logic [IdW-1:0] HashMult = 32'h61C88647;

  typedef enum logic [1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_ADD    = 2'd1,
    MODE_DELETE = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_PRESENT  = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef struct packed {
    logic capture;
    logic exec;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

  // The bucket count is a power of two, so only the low bits of the product matter.
  function automatic logic [BucketW-1:0] bucket_of(input logic [IdW-1:0] id);
    logic [BucketW-1:0] prod;
    prod = id[BucketW-1:0] * HashMult[BucketW-1:0];
    return prod;
  endfunction

endpackage

`default_nettype wire

>>> rtl/hims_req_if.sv
// Request channel carrying one operation and its track ID.
`default_nettype none

interface hims_req_if;
  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic signed [31:0] track_id;

  modport source(output valid, output mode, output track_id, input ready);
  modport sink(input valid, input mode, input track_id, output ready);
endinterface

`default_nettype wire

>>> rtl/hims_rsp_if.sv
// Response channel carrying the found flag and status of one operation.
`default_nettype none

interface hims_rsp_if;
  logic       valid;
  logic       ready;
  logic       found;
  logic [1:0] status;

  modport source(output valid, output found, output status, input ready);
  modport sink(input valid, input found, input status, output ready);
endinterface

`default_nettype wire

>>> rtl/hims_ctrl.sv
// Controller state machine that sequences the read and execute phases of each operation.
`default_nettype none

module hims_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  req_valid_i,
  input  hims_pkg::dp_stat_t   stat_i,
  output logic                 req_ready_o,
  output hims_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q, state_d;
  logic   ready_q;

  always_comb begin
    cmd_o.capture = req_valid_i && ready_q;
    cmd_o.exec    = 1'b0;
    state_d       = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_o.capture) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ready_q <= 1'b1;
    end else begin
      state_q <= state_d;
      ready_q <= (state_d == S_IDLE);
    end
  end

  assign req_ready_o = ready_q;

endmodule

`default_nettype wire

>>> rtl/hims_dp.sv
// Datapath with the slot ID memory, slot valid bits, way compare and response register.
`default_nettype none

module hims_dp (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  hims_pkg::ctrl_cmd_t               cmd_i,
  output hims_pkg::dp_stat_t                stat_o,
  input  wire  [1:0]                        mode_i,
  input  wire  [hims_pkg::IdW-1:0]          track_id_i,
  input  wire                               rsp_ready_i,
  output logic                              rsp_valid_o,
  output logic                              rsp_found_o,
  output logic [1:0]                        rsp_status_o
);

  logic [hims_pkg::IdW-1:0] slot_mem [hims_pkg::Buckets][hims_pkg::Ways];
  logic [hims_pkg::IdW-1:0] rd_row_q [hims_pkg::Ways];

  logic [hims_pkg::Buckets-1:0][hims_pkg::Ways-1:0] valid_q, valid_d;

  hims_pkg::mode_e              mode_q;
  logic [hims_pkg::IdW-1:0]     id_q;
  logic [hims_pkg::BucketW-1:0] bucket_q;

  logic                         out_valid_q, out_valid_d;
  logic                         out_found_q;
  hims_pkg::status_e            out_status_q;

  logic [hims_pkg::Ways-1:0]    row_valid;
  logic [hims_pkg::Ways-1:0]    hit;
  logic [hims_pkg::WayW-1:0]    hit_way;
  logic [hims_pkg::WayW-1:0]    free_way;
  logic                         found;
  logic                         has_free;
  logic                         wr_en;
  hims_pkg::status_e            status;
  logic                         res_found;

  always_comb begin
    row_valid = valid_q[bucket_q];
    hit_way   = '0;
    free_way  = '0;
    for (int w = hims_pkg::Ways - 1; w >= 0; w--) begin
      hit[w] = row_valid[w] && (rd_row_q[w] == id_q);
      if (hit[w]) begin
        hit_way = hims_pkg::WayW'(w);
      end
      if (!row_valid[w]) begin
        free_way = hims_pkg::WayW'(w);
      end
    end
    found    = |hit;
    has_free = ~&row_valid;
  end

  always_comb begin
    valid_d   = valid_q;
    wr_en     = 1'b0;
    res_found = found;
    status    = hims_pkg::ST_OK;
    case (mode_q)
      hims_pkg::MODE_LOOKUP: begin
        status = found ? hims_pkg::ST_OK : hims_pkg::ST_NOTFOUND;
      end
      hims_pkg::MODE_ADD: begin
        if (found) begin
          status = hims_pkg::ST_PRESENT;
        end else if (has_free) begin
          status = hims_pkg::ST_OK;
          wr_en  = cmd_i.exec;
          if (cmd_i.exec) begin
            valid_d[bucket_q][free_way] = 1'b1;
          end
        end else begin
          status = hims_pkg::ST_FULL;
        end
      end
      hims_pkg::MODE_DELETE: begin
        if (found) begin
          status = hims_pkg::ST_OK;
          if (cmd_i.exec) begin
            valid_d[bucket_q][hit_way] = 1'b0;
          end
        end else begin
          status = hims_pkg::ST_NOTFOUND;
        end
      end
      default: begin
        res_found = 1'b0;
        status    = hims_pkg::ST_OK;
        if (cmd_i.exec) begin
          valid_d = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_mem[bucket_q][free_way] <= id_q;
    end
    if (cmd_i.capture) begin
      rd_row_q <= slot_mem[hims_pkg::bucket_of(track_id_i)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q   <= hims_pkg::mode_e'(mode_i);
      id_q     <= track_id_i;
      bucket_q <= hims_pkg::bucket_of(track_id_i);
    end
    if (cmd_i.exec) begin
      out_found_q  <= res_found;
      out_status_q <= status;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.exec) begin
      out_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign stat_o.out_free = !out_valid_q || rsp_ready_i;
  assign rsp_valid_o     = out_valid_q;
  assign rsp_found_o     = out_found_q;
  assign rsp_status_o    = out_status_q;

endmodule

`default_nettype wire

>>> rtl/hashed_id_membership_set.sv
// Top level of the hashed ID membership set.
`default_nettype none

// The block holds up to 256 IDs in 64 buckets of 4 ways and performs one lookup, add, delete
// or clear-all per request transaction, answering with one response transaction that carries
// the found flag and a status. Each operation has a read phase that registers the bucket's row
// from the ID memory, and an execute phase that compares all ways at once, updates the valid
// bits or writes the new ID, and loads the response register. A new request is taken while an
// earlier response still waits; an operation only stalls in its execute phase if that response
// is not yet taken. Clear-all drops every valid bit at once, and no clearing pass is needed
// after reset.
module hashed_id_membership_set (
  input  wire        clk_i,
  input  wire        rst_ni,
  hims_req_if.sink   req_i,
  hims_rsp_if.source rsp_o
);

  hims_pkg::ctrl_cmd_t cmd;
  hims_pkg::dp_stat_t  stat;

  hims_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .stat_i      (stat),
    .req_ready_o (req_i.ready),
    .cmd_o       (cmd)
  );

  hims_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .mode_i       (req_i.mode),
    .track_id_i   (req_i.track_id),
    .rsp_ready_i  (rsp_o.ready),
    .rsp_valid_o  (rsp_o.valid),
    .rsp_found_o  (rsp_o.found),
    .rsp_status_o (rsp_o.status)
  );

  a_no_capture_and_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.capture && cmd.exec))
    else $error("Capture and execute issued in the same cycle.");

  a_exec_needs_free_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.exec |-> stat.out_free)
    else $error("Execute issued while the response register is still occupied.");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("Request taken while a previous operation is in progress.");

  a_rsp_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_o.valid) |-> $past(cmd.exec))
    else $error("Response transaction appeared without an executed operation.");

endmodule

`default_nettype wire
